// ===== rtl/lsrk_pkg.sv =====
// Shared types, constants and codes for the keyed-delete LIFO stack.
package lsrk_pkg;

	// Number of records the stack holds (2 to 127).
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = 7;

	// Command codes.
	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;

	// Status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] key_name;
		logic [7:0]  age;
	} lsrk_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [63:0]      out_name;
		logic [7:0]       out_age;
		logic [CNT_W-1:0] count;
		logic             last;
	} lsrk_res_t;

	// One stored record.
	typedef struct packed {
		logic [63:0] name;
		logic [7:0]  age;
	} lsrk_entry_t;

	// Movement of the cell row in one cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_DOWN,
		CELL_UP
	} lsrk_mode_t;

	// Control broadcast from the sequencer to the cell row.
	typedef struct packed {
		lsrk_mode_t       mode;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
	} lsrk_cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIST,
		S_REMOVE
	} lsrk_state_t;

endpackage

// ===== rtl/lsrk_cell.sv =====
// One storage cell of the stack row.
module lsrk_cell (
	input  logic                 clk,
	input  lsrk_pkg::lsrk_mode_t mode,
	input  logic                 wr_hit,
	input  lsrk_pkg::lsrk_entry_t up_in,
	input  lsrk_pkg::lsrk_entry_t down_in,
	input  lsrk_pkg::lsrk_entry_t bcast,
	output lsrk_pkg::lsrk_entry_t entry
);
	import lsrk_pkg::*;

	lsrk_entry_t entry_q;

	// Shift toward the bottom on push, toward the top on pop or walk; the
	// tail of the ring picks up the broadcast top record while walking.
	always_ff @(posedge clk) begin
		case (mode)
			CELL_DOWN: entry_q <= down_in;
			CELL_UP: begin
				if (wr_hit) begin
					entry_q <= bcast;
				end else begin
					entry_q <= up_in;
				end
			end
			default: entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

// ===== rtl/lsrk_ctrl.sv =====
// Command sequencer: fill count, list and remove walks, result register.
module lsrk_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  lsrk_pkg::lsrk_req_t       request,
	input  lsrk_pkg::lsrk_entry_t     top,
	output lsrk_pkg::lsrk_cell_ctl_t  cell_ctl,
	output logic                      busy,
	output logic                      done,
	output lsrk_pkg::lsrk_res_t       result
);
	import lsrk_pkg::*;

	lsrk_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic             found_q, found_d;
	logic [63:0]      key_q, key_d;
	lsrk_entry_t      hit_q, hit_d;
	lsrk_res_t        res_q, res_d;
	logic             done_q, done_d;
	logic             match;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			found_q <= found_d;
			done_q  <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		key_q <= key_d;
		hit_q <= hit_d;
		res_q <= res_d;
	end

	// The first matching record seen during a remove walk is the topmost.
	assign match = !found_q && (top.name == key_q);

	// Next state, cell control and result.
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		step_d          = step_q;
		found_d         = found_q;
		key_d           = key_q;
		hit_d           = hit_q;
		res_d           = res_q;
		done_d          = 1'b0;
		cell_ctl.mode   = CELL_HOLD;
		cell_ctl.wr_en  = 1'b0;
		cell_ctl.wr_idx = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					res_d.status   = STAT_OK;
					res_d.out_name = '0;
					res_d.out_age  = '0;
					res_d.last     = 1'b1;
					res_d.count    = count_q;
					done_d         = 1'b1;
					case (request.command)
						CMD_PUSH: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_d.status = STAT_FULL;
							end else begin
								cell_ctl.mode = CELL_DOWN;
								count_d       = count_q + 1'b1;
								res_d.count   = count_q + 1'b1;
							end
						end
						CMD_POP: begin
							if (count_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								cell_ctl.mode  = CELL_UP;
								count_d        = count_q - 1'b1;
								res_d.count    = count_q - 1'b1;
								res_d.out_name = top.name;
								res_d.out_age  = top.age;
							end
						end
						CMD_REMOVE: begin
							if (count_q == '0) begin
								res_d.status = STAT_NOTFOUND;
							end else begin
								done_d  = 1'b0;
								key_d   = request.key_name;
								step_d  = count_q;
								found_d = 1'b0;
								state_d = S_REMOVE;
							end
						end
						CMD_CLEAR: begin
							count_d     = '0;
							res_d.count = '0;
						end
						CMD_LIST: begin
							if (count_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								done_d  = 1'b0;
								step_d  = count_q;
								state_d = S_LIST;
							end
						end
						default: begin
							res_d.status = STAT_OK;
						end
					endcase
				end
			end
			S_LIST: begin
				// Rotate the ring once, reporting the top record each cycle.
				cell_ctl.mode   = CELL_UP;
				cell_ctl.wr_en  = 1'b1;
				cell_ctl.wr_idx = IDX_W'(count_q - 1'b1);
				res_d.status    = STAT_OK;
				res_d.out_name  = top.name;
				res_d.out_age   = top.age;
				res_d.count     = count_q;
				res_d.last      = (step_q == CNT_W'(1));
				done_d          = 1'b1;
				step_d          = step_q - 1'b1;
				if (step_q == CNT_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			S_REMOVE: begin
				// Rotate the ring once; the first match is dropped instead of
				// being written back, which shortens the ring by one.
				cell_ctl.mode = CELL_UP;
				if (match) begin
					count_d = count_q - 1'b1;
					found_d = 1'b1;
					hit_d   = top;
				end else begin
					cell_ctl.wr_en  = 1'b1;
					cell_ctl.wr_idx = IDX_W'(count_q - 1'b1);
				end
				step_d = step_q - 1'b1;
				if (step_q == CNT_W'(1)) begin
					done_d      = 1'b1;
					state_d     = S_IDLE;
					res_d.last  = 1'b1;
					res_d.count = match ? (count_q - 1'b1) : count_q;
					if (match) begin
						res_d.status   = STAT_OK;
						res_d.out_name = top.name;
						res_d.out_age  = top.age;
					end else if (found_q) begin
						res_d.status   = STAT_OK;
						res_d.out_name = hit_q.name;
						res_d.out_age  = hit_q.age;
					end else begin
						res_d.status   = STAT_NOTFOUND;
						res_d.out_name = '0;
						res_d.out_age  = '0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/lifo_stack_with_remove_by_key.sv =====
// Top level of the bounded LIFO stack with remove by key.
//
//   Channel   Signals                 Direction  Handshake
//   request   start, busy, request    in         taken when start && !busy
//   result    done, result            out        one-cycle strobe on done
//
// Push, pop, clear and unknown commands complete from the idle state; the
// result appears in the cycle after the request is taken. List and remove of
// a non-empty stack rotate the cell row once, one record per cycle, so busy
// stays high until every record held (up to DEPTH) has passed the top. List
// reports one result per cycle of the rotation, each registered from the top
// cell while in the list state; remove registers its single result at the last
// step of the rotation. On an empty stack both finish like push. Reset empties
// the stack; stored records are not cleared. The receiver cannot stall results.
module lifo_stack_with_remove_by_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lsrk_pkg::lsrk_req_t request,
	output logic                busy,
	output logic                done,
	output lsrk_pkg::lsrk_res_t result
);
	import lsrk_pkg::*;

	lsrk_cell_ctl_t cell_ctl;
	lsrk_entry_t    cells [DEPTH];
	lsrk_entry_t    push_entry;

	assign push_entry.name = request.key_name;
	assign push_entry.age  = request.age;

	// Sequencer.
	lsrk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !busy),
		.request  (request),
		.top      (cells[0]),
		.cell_ctl (cell_ctl),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	// Row of cells; cell 0 holds the top of the stack.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lsrk_entry_t up_in;
		lsrk_entry_t down_in;
		logic        wr_hit;

		if (i == 0) begin : g_first
			assign down_in = push_entry;
		end else begin : g_mid
			assign down_in = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign up_in = '0;
		end else begin : g_inner
			assign up_in = cells[i+1];
		end

		assign wr_hit = cell_ctl.wr_en && (cell_ctl.wr_idx == IDX_W'(i));

		lsrk_cell u_cell (
			.clk     (clk),
			.mode    (cell_ctl.mode),
			.wr_hit  (wr_hit),
			.up_in   (up_in),
			.down_in (down_in),
			.bcast   (cells[0]),
			.entry   (cells[i])
		);
	end

	// The reported fill never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.count <= CNT_W'(DEPTH)))
		else $error("result count above capacity");

	// A list result without the last marker is followed by another result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last) |=> done)
		else $error("list results not back to back");

	// Push, pop and clear report one final result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_PUSH ||
			request.command == CMD_POP || request.command == CMD_CLEAR))
		|=> (done && result.last && !busy))
		else $error("single-cycle command did not complete");

	// Failing results carry no record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
		(result.out_name == '0 && result.out_age == '0))
		else $error("failing result carries a record");

endmodule

// ===== tb/lifo_stack_with_remove_by_key_test.sv =====
// Self-checking testbench for the LIFO record stack with remove by key.
`timescale 1ns / 100ps

module lifo_stack_with_remove_by_key_test;
	import lsrk_pkg::*;

	// Command codes that the block ignores.
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int KEY_POOL_SIZE  = 6;
	localparam int RANDOM_SINGLES = 175;

	// One queued request with the idle cycles that come before it.
	typedef struct packed {
		lsrk_req_t  req;
		logic [7:0] gap;
		logic       drain;
	} queued_req_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	lsrk_req_t request = '0;
	logic      busy;
	logic      done;
	lsrk_res_t result;

	queued_req_t request_backlog[$];
	queued_req_t next_req;
	logic        next_loaded = 1'b0;
	lsrk_res_t   expected_results[$];
	lsrk_res_t   want;
	int          fail_count = 0;
	int          stall_cycles = 0;
	int          calm_left = 0;

	// Predicted contents of the stack, bottom first.
	lsrk_entry_t shadow_records[DEPTH];
	int          shadow_fill = 0;

	logic [63:0] key_pool[KEY_POOL_SIZE];

	lifo_stack_with_remove_by_key u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always #10 clk = ~clk;

	// Works out the results of one accepted request and updates the predicted stack.
	task automatic predict_stack(input lsrk_req_t req);
		lsrk_res_t res;
		int        hit;
		int        i;
		res = '0;
		res.last = 1'b1;
		hit = -1;
		case (req.command)
		CMD_PUSH: begin
			if (shadow_fill == DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				shadow_records[shadow_fill] = {req.key_name, req.age};
				shadow_fill++;
			end
		end
		CMD_POP: begin
			if (shadow_fill == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				shadow_fill--;
				res.out_name = shadow_records[shadow_fill].name;
				res.out_age = shadow_records[shadow_fill].age;
			end
		end
		CMD_REMOVE: begin
			for (i = shadow_fill - 1; i >= 0; i--) begin
				if (hit < 0 && shadow_records[i].name == req.key_name)
					hit = i;
			end
			if (hit < 0) begin
				res.status = STAT_NOTFOUND;
			end else begin
				res.out_name = shadow_records[hit].name;
				res.out_age = shadow_records[hit].age;
				// Records above the match move down one place.
				for (i = hit; i < shadow_fill - 1; i++)
					shadow_records[i] = shadow_records[i + 1];
				shadow_fill--;
			end
		end
		CMD_CLEAR: begin
			shadow_fill = 0;
		end
		CMD_LIST: begin
			if (shadow_fill == 0)
				res.status = STAT_EMPTY;
			// A non-empty list gives one result per record, top first.
			for (i = 0; i < shadow_fill; i++) begin
				res.out_name = shadow_records[shadow_fill - 1 - i].name;
				res.out_age = shadow_records[shadow_fill - 1 - i].age;
				res.count = CNT_W'(shadow_fill);
				res.last = (i == shadow_fill - 1);
				expected_results.push_back(res);
			end
		end
		default: begin
		end
		endcase
		if (!(req.command == CMD_LIST && shadow_fill != 0)) begin
			res.count = CNT_W'(shadow_fill);
			expected_results.push_back(res);
		end
	endtask

	// Queues one request, choosing the idle gap before it.
	task automatic queue_req(input logic [2:0] cmd, input logic [63:0] key,
			input logic [7:0] age, input logic drain);
		queued_req_t item;
		int          pick;
		item.req.command = cmd;
		item.req.key_name = key;
		item.req.age = age;
		item.drain = drain;
		pick = $urandom_range(0, 99);
		if (calm_left != 0) begin
			calm_left--;
			item.gap = '0;
		end else if (pick < 4) begin
			calm_left = $urandom_range(10, 30);
			item.gap = '0;
		end else if (pick < 50) begin
			item.gap = '0;
		end else if (pick < 85) begin
			item.gap = 8'($urandom_range(1, 3));
		end else if (pick < 97) begin
			item.gap = 8'($urandom_range(4, 12));
		end else begin
			item.gap = 8'($urandom_range(20, 60));
		end
		request_backlog.push_back(item);
	endtask

	// Keys mostly come from a small pool so that removes often find a match.
	function automatic logic [63:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	// Any age value.
	function automatic logic [7:0] rand_age();
		return 8'($urandom_range(0, 255));
	endfunction

	// Driver: presents queued requests and holds each until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else if (!start || !busy) begin
			if (start)
				predict_stack(request);
			if (!next_loaded && request_backlog.size() != 0) begin
				next_req = request_backlog.pop_front();
				next_loaded = 1'b1;
			end
			if (next_loaded && next_req.gap != 0) begin
				next_req.gap = next_req.gap - 1'b1;
				start <= 1'b0;
			end else if (next_loaded && !(next_req.drain && expected_results.size() != 0)) begin
				request <= next_req.req;
				start <= 1'b1;
				next_loaded = 1'b0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compares each result with the oldest prediction.
	always @(posedge clk) begin
		if (done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d name %h age %0d count %0d last %0d",
					result.status, result.out_name, result.out_age, result.count,
					result.last);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.out_name !== want.out_name) begin
					$error("out_name: expected %h, got %h", want.out_name, result.out_name);
					fail_count++;
				end
				if (result.out_age !== want.out_age) begin
					$error("out_age: expected %0d, got %0d", want.out_age, result.out_age);
					fail_count++;
				end
				if (result.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, result.count);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// Counts cycles in which no request is taken and no result appears.
	always @(posedge clk) begin
		stall_cycles <= ((start && !busy) || done) ? 0 : stall_cycles + 1;
	end

	// Watchdog.
	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [63:0] bottom_key;
		int          n;
		int          pick;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (n = 2; n < KEY_POOL_SIZE; n++)
			key_pool[n] = {$urandom, $urandom};

		// Directed: empty stack, field extremes, duplicate keys and ignored codes.
		queue_req(CMD_POP, {$urandom, $urandom}, rand_age(), 1'b0);
		queue_req(CMD_LIST, {$urandom, $urandom}, rand_age(), 1'b0);
		queue_req(CMD_REMOVE, '1, 8'd0, 1'b0);
		queue_req(CMD_SPARE_FIRST, '1, 8'hff, 1'b0);
		queue_req(CMD_PUSH, '0, 8'd0, 1'b0);
		queue_req(CMD_PUSH, '1, 8'hff, 1'b0);
		queue_req(CMD_PUSH, 64'ha5a5_a5a5_a5a5_a5a5, 8'h5a, 1'b0);
		queue_req(CMD_LIST, '0, 8'd0, 1'b0);
		queue_req(CMD_REMOVE, '1, 8'd0, 1'b0);
		queue_req(CMD_REMOVE, '1, 8'd0, 1'b0);
		queue_req(CMD_POP, '0, 8'd0, 1'b0);
		queue_req(CMD_PUSH, 64'h0123_4567_89ab_cdef, 8'd1, 1'b0);
		queue_req(CMD_PUSH, 64'h0123_4567_89ab_cdef, 8'd2, 1'b0);
		queue_req(CMD_PUSH, 64'hfedc_ba98_7654_3210, 8'd3, 1'b0);
		queue_req(CMD_REMOVE, 64'h0123_4567_89ab_cdef, 8'd0, 1'b0);
		queue_req(CMD_LIST, '1, 8'hff, 1'b0);
		queue_req(CMD_CLEAR, '1, 8'hff, 1'b0);
		queue_req(CMD_LIST, '0, 8'd0, 1'b0);
		queue_req(CMD_POP, '1, 8'hff, 1'b0);
		queue_req(CMD_SPARE_LAST, '0, 8'd0, 1'b0);
		queue_req(CMD_PUSH, '1, 8'h80, 1'b0);
		queue_req(CMD_REMOVE, '1, 8'd0, 1'b0);
		queue_req(CMD_REMOVE, '0, 8'd0, 1'b0);

		// Fill to the brim after a full drain, then overflow, list and remove.
		bottom_key = {$urandom, $urandom};
		queue_req(CMD_CLEAR, {$urandom, $urandom}, rand_age(), 1'b1);
		queue_req(CMD_PUSH, bottom_key, rand_age(), 1'b0);
		for (n = 1; n < DEPTH; n++)
			queue_req(CMD_PUSH, pick_key(), rand_age(), 1'b0);
		queue_req(CMD_PUSH, {$urandom, $urandom}, rand_age(), 1'b0);
		queue_req(CMD_PUSH, pick_key(), rand_age(), 1'b0);
		queue_req(CMD_LIST, {$urandom, $urandom}, rand_age(), 1'b0);
		queue_req(CMD_REMOVE, bottom_key, rand_age(), 1'b0);
		queue_req(CMD_PUSH, pick_key(), rand_age(), 1'b0);
		queue_req(CMD_REMOVE, {$urandom, $urandom}, rand_age(), 1'b0);
		queue_req(CMD_LIST, {$urandom, $urandom}, rand_age(), 1'b1);

		// Random mix, weighted toward pushes so the stack grows deep.
		for (n = 0; n < RANDOM_SINGLES; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 42)
				queue_req(CMD_PUSH, pick_key(), rand_age(),
					$urandom_range(0, 49) == 0);
			else if (pick < 57)
				queue_req(CMD_POP, {$urandom, $urandom}, rand_age(), 1'b0);
			else if (pick < 78)
				queue_req(CMD_REMOVE, pick_key(), rand_age(), 1'b0);
			else if (pick < 88)
				queue_req(CMD_LIST, {$urandom, $urandom}, rand_age(), 1'b0);
			else if (pick < 92)
				queue_req(CMD_CLEAR, {$urandom, $urandom}, rand_age(), 1'b0);
			else
				queue_req(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
					{$urandom, $urandom}, rand_age(), 1'b0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken and every result to arrive.
		while (request_backlog.size() != 0 || next_loaded || start ||
				expected_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
